// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LSTS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define LSTS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/lsts_pkg.sv =====
// ----------------------------------------------------------------------------
// lsts_pkg
// Types, constants and the arctangent table of the triangle solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsts_pkg;

	localparam int SINE_STEPS_DEF      = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int ATAN_ENTRIES        = 24;
	localparam int CW                  = 34;
	localparam int QBITS               = 32;

	localparam logic [24:0] DEG_TO_RAD = 25'd18740330;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

	localparam logic [1:0] OP_ALPHA = 2'd0;
	localparam logic [1:0] OP_BETA  = 2'd1;
	localparam logic [1:0] OP_GAMMA = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;
	localparam logic [1:0] SIDE_NONE = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ANGLE = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	typedef struct packed {
		logic        inval;
		logic [1:0]  ks;
		logic [15:0] third;
		logic [31:0] len;
	} meta_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} lane_t;

	typedef struct packed {
		meta_t           meta;
		lane_t [2:0]     lane;
	} cordic_t;

	typedef struct packed {
		meta_t             meta;
		logic              bad;
		logic [30:0]       dvs;
		logic [2:0][30:0]  rem;
		logic [2:0][31:0]  nlo;
		logic [2:0][31:0]  quo;
		logic [2:0]        ovf;
	} div_t;

	function automatic logic [29:0] atan_q30(input int idx);
		logic [29:0] v;
		case (idx)
			0:  v = 30'd843314856;
			1:  v = 30'd497837829;
			2:  v = 30'd263043836;
			3:  v = 30'd133525158;
			4:  v = 30'd67021686;
			5:  v = 30'd33543515;
			6:  v = 30'd16775850;
			7:  v = 30'd8388437;
			8:  v = 30'd4194282;
			9:  v = 30'd2097149;
			10: v = 30'd1048575;
			11: v = 30'd524287;
			12: v = 30'd262143;
			13: v = 30'd131071;
			14: v = 30'd65535;
			15: v = 30'd32767;
			16: v = 30'd16383;
			17: v = 30'd8191;
			18: v = 30'd4095;
			19: v = 30'd2047;
			20: v = 30'd1023;
			21: v = 30'd511;
			22: v = 30'd255;
			23: v = 30'd127;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/lsts_front.sv =====
// ----------------------------------------------------------------------------
// lsts_front
// Angle decode, third angle, fold to the first quadrant, degrees to radians.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsts_front #(
	parameter int ANGLE_FRAC_BITS = lsts_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [1:0]          known_side,
	input  logic [15:0]         first_angle,
	input  logic [15:0]         second_angle,
	input  logic [31:0]         side_length,
	output logic                out_valid,
	input  logic                out_ready,
	output lsts_pkg::cordic_t   out_data
);

	localparam int AW = (ANGLE_FRAC_BITS + 9 > 17) ? ANGLE_FRAC_BITS + 9 : 17;
	localparam int PW = AW + 25;
	localparam logic [AW-1:0] HALF    = AW'(180 << ANGLE_FRAC_BITS);
	localparam logic [AW-1:0] QUARTER = AW'(90 << ANGLE_FRAC_BITS);

	logic [AW-1:0]       sum;
	logic [AW-1:0]       third;
	logic                inval;
	logic [2:0][AW-1:0]  ang;
	logic [2:0][AW-1:0]  fold;
	logic [2:0][PW-1:0]  prod;
	lsts_pkg::cordic_t   nxt;
	logic                vld_s1;
	lsts_pkg::cordic_t   dat_s1;

	assign sum   = AW'(first_angle) + AW'(second_angle);
	assign inval = (op == lsts_pkg::OP_NONE) || (sum >= HALF);
	assign third = HALF - sum;

	always_comb begin
		unique case (op)
			lsts_pkg::OP_ALPHA: begin
				ang[0] = third;
				ang[1] = AW'(first_angle);
				ang[2] = AW'(second_angle);
			end
			lsts_pkg::OP_BETA: begin
				ang[0] = AW'(first_angle);
				ang[1] = third;
				ang[2] = AW'(second_angle);
			end
			default: begin
				ang[0] = AW'(first_angle);
				ang[1] = AW'(second_angle);
				ang[2] = third;
			end
		endcase
	end

	always_comb begin
		nxt.meta.inval = inval;
		nxt.meta.ks    = known_side;
		nxt.meta.third = third[15:0];
		nxt.meta.len   = side_length;
		for (int k = 0; k < 3; k++) begin
			fold[k] = (ang[k] > QUARTER) ? HALF - ang[k] : ang[k];
			prod[k] = PW'(fold[k]) * PW'(lsts_pkg::DEG_TO_RAD);
			nxt.lane[k].x = lsts_pkg::CORDIC_GAIN;
			nxt.lane[k].y = '0;
			nxt.lane[k].z = {3'b000, prod[k][ANGLE_FRAC_BITS +: 31]};
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;

endmodule

// ===== rtl/lsts_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// lsts_cordic_stage
// One rotation-mode CORDIC iteration for the three angle lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsts_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lsts_pkg::cordic_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lsts_pkg::cordic_t   out_data
);

	localparam logic signed [lsts_pkg::CW-1:0] ATAN =
		{{(lsts_pkg::CW-30){1'b0}}, lsts_pkg::atan_q30(IDX)};

	lsts_pkg::cordic_t nxt;
	logic              vld_s1;
	lsts_pkg::cordic_t dat_s1;

	always_comb begin
		logic signed [lsts_pkg::CW-1:0] dx;
		logic signed [lsts_pkg::CW-1:0] dy;
		nxt.meta = in_data.meta;
		for (int k = 0; k < 3; k++) begin
			dx = $signed(in_data.lane[k].y) >>> IDX;
			dy = $signed(in_data.lane[k].x) >>> IDX;
			if (!in_data.lane[k].z[lsts_pkg::CW-1]) begin
				nxt.lane[k].x = in_data.lane[k].x - dx;
				nxt.lane[k].y = in_data.lane[k].y + dy;
				nxt.lane[k].z = in_data.lane[k].z - ATAN;
			end else begin
				nxt.lane[k].x = in_data.lane[k].x + dx;
				nxt.lane[k].y = in_data.lane[k].y - dy;
				nxt.lane[k].z = in_data.lane[k].z + ATAN;
			end
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;

endmodule

// ===== rtl/lsts_div_stage.sv =====
// ----------------------------------------------------------------------------
// lsts_div_stage
// One restoring-division step: one quotient bit for each of the three lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsts_div_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lsts_pkg::div_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lsts_pkg::div_t   out_data
);

	lsts_pkg::div_t nxt;
	logic           vld_s1;
	lsts_pkg::div_t dat_s1;

	always_comb begin
		logic [31:0] r2;
		logic [31:0] nr;
		logic        ge;
		nxt = in_data;
		for (int k = 0; k < 3; k++) begin
			r2 = {in_data.rem[k], in_data.nlo[k][31]};
			ge = r2 >= {1'b0, in_data.dvs};
			nr = ge ? r2 - {1'b0, in_data.dvs} : r2;
			nxt.rem[k] = nr[30:0];
			nxt.nlo[k] = {in_data.nlo[k][30:0], 1'b0};
			nxt.quo[k] = {in_data.quo[k][30:0], ge};
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;

endmodule

// ===== rtl/law_of_sines_triangle_solver.sv =====
// ----------------------------------------------------------------------------
// law_of_sines_triangle_solver
// Third angle and all three sides from two angles and one side.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready/s_tdata, one triangle per beat;
// results leave on m_tvalid/m_tready/m_tdata, one beat per triangle, in order.
// The pipeline has one decode stage, one CORDIC stage per rotation, a multiply
// stage, a divider setup stage, 32 restoring-division stages (one quotient bit
// each) and the output register.
// Throughput is one beat per cycle while the receiver does not stall; every stage holds its own valid bit.
// A stalled receiver only halts stages that hold data; empty stages behind
// them keep filling, so s_tready falls only once the pipeline is full.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// Status codes: ok, angle sum invalid, zero divisor sine or no known side, side saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module law_of_sines_triangle_solver #(
	parameter int SINE_STEPS      = lsts_pkg::SINE_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = lsts_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[1:0], known_side[3:2], first_angle[19:4], second_angle[35:20],
	// side_length[67:36], zero fill
	input  logic [71:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// third_angle[15:0], side_a[47:16], side_b[79:48], side_c[111:80],
	// status[113:112], zero fill
	output logic [119:0] m_tdata
);

	localparam int NSTEP = (SINE_STEPS < lsts_pkg::ATAN_ENTRIES) ?
		SINE_STEPS : lsts_pkg::ATAN_ENTRIES;
	localparam int QB = lsts_pkg::QBITS;

	lsts_pkg::cordic_t cd [0:NSTEP];
	logic              cv [0:NSTEP];
	logic              cr [0:NSTEP];

	lsts_pkg::div_t    dd [0:QB];
	logic              dv [0:QB];
	logic              dr [0:QB];

	logic              rdy_p;
	logic              rdy_o;

	lsts_front #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.op          (s_tdata[1:0]),
		.known_side  (s_tdata[3:2]),
		.first_angle (s_tdata[19:4]),
		.second_angle(s_tdata[35:20]),
		.side_length (s_tdata[67:36]),
		.out_valid   (cv[0]),
		.out_ready   (cr[0]),
		.out_data    (cd[0])
	);

	for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
		lsts_cordic_stage #(
			.IDX(i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[i]),
			.in_ready (cr[i]),
			.in_data  (cd[i]),
			.out_valid(cv[i+1]),
			.out_ready(cr[i+1]),
			.out_data (cd[i+1])
		);
	end

	// sine clamp and numerator product
	logic [2:0][30:0]      sn;
	logic [30:0]           sn_ks;
	logic                  pv_s1;
	lsts_pkg::meta_t       pmeta_s1;
	logic                  pbad_s1;
	logic [30:0]           pdvs_s1;
	logic [2:0][62:0]      pnum_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (cd[NSTEP].lane[k].y[lsts_pkg::CW-1]) begin
				sn[k] = '0;
			end else if ($signed(cd[NSTEP].lane[k].y) > lsts_pkg::ONE_Q30) begin
				sn[k] = 31'(lsts_pkg::ONE_Q30);
			end else begin
				sn[k] = cd[NSTEP].lane[k].y[30:0];
			end
		end
		case (cd[NSTEP].meta.ks)
			2'd0:    sn_ks = sn[0];
			2'd1:    sn_ks = sn[1];
			2'd2:    sn_ks = sn[2];
			default: sn_ks = '0;
		endcase
	end

	assign cr[NSTEP] = rdy_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else if (rdy_p) begin
			pv_s1 <= cv[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_p && cv[NSTEP]) begin
			pmeta_s1 <= cd[NSTEP].meta;
			pbad_s1  <= (cd[NSTEP].meta.ks == lsts_pkg::SIDE_NONE) || (sn_ks == '0);
			pdvs_s1  <= sn_ks;
			for (int k = 0; k < 3; k++) begin
				pnum_s1[k] <= 63'(cd[NSTEP].meta.len) * 63'(sn[k]);
			end
		end
	end

	// divider setup: overflow check and first partial remainder
	logic            iv_s2;
	lsts_pkg::div_t  idat_s2;
	logic            rdy_i;

	assign rdy_i = !iv_s2 || dr[0];
	assign rdy_p = !pv_s1 || rdy_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_s2 <= 1'b0;
		end else if (rdy_i) begin
			iv_s2 <= pv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_i && pv_s1) begin
			idat_s2.meta <= pmeta_s1;
			idat_s2.bad  <= pbad_s1;
			idat_s2.dvs  <= pdvs_s1;
			for (int k = 0; k < 3; k++) begin
				idat_s2.rem[k] <= pnum_s1[k][62:32];
				idat_s2.nlo[k] <= pnum_s1[k][31:0];
				idat_s2.quo[k] <= '0;
				idat_s2.ovf[k] <= pnum_s1[k][62:32] >= pdvs_s1;
			end
		end
	end

	assign dv[0] = iv_s2;
	assign dd[0] = idat_s2;

	for (genvar j = 0; j < QB; j++) begin : g_div
		lsts_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv[j]),
			.in_ready (dr[j]),
			.in_data  (dd[j]),
			.out_valid(dv[j+1]),
			.out_ready(dr[j+1]),
			.out_data (dd[j+1])
		);
	end

	// result assembly
	logic [15:0]      o_third;
	logic [2:0][31:0] o_side;
	logic [1:0]       o_status;
	logic             ov_s3;
	logic [15:0]      third_s3;
	logic [2:0][31:0] side_s3;
	logic [1:0]       status_s3;

	always_comb begin
		o_third  = dd[QB].meta.third;
		o_status = lsts_pkg::ST_OK;
		o_side   = '0;
		if (dd[QB].meta.inval) begin
			o_third  = '0;
			o_status = lsts_pkg::ST_ANGLE;
		end else if (dd[QB].bad) begin
			o_status = lsts_pkg::ST_ZERO;
			for (int k = 0; k < 3; k++) begin
				if (dd[QB].meta.ks == 2'(k)) begin
					o_side[k] = dd[QB].meta.len;
				end
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (dd[QB].meta.ks == 2'(k)) begin
					o_side[k] = dd[QB].meta.len;
				end else if (dd[QB].ovf[k]) begin
					o_side[k] = '1;
					o_status  = lsts_pkg::ST_SAT;
				end else begin
					o_side[k] = dd[QB].quo[k];
				end
			end
		end
	end

	assign rdy_o  = !ov_s3 || m_tready;
	assign dr[QB] = rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s3 <= 1'b0;
		end else if (rdy_o) begin
			ov_s3 <= dv[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && dv[QB]) begin
			third_s3  <= o_third;
			side_s3   <= o_side;
			status_s3 <= o_status;
		end
	end

	assign m_tvalid = ov_s3;
	assign m_tdata  = {6'b0, status_s3, side_s3[2], side_s3[1], side_s3[0], third_s3};

endmodule

// ===== rtl/lsts_checker.sv =====
// ----------------------------------------------------------------------------
// lsts_checker
// Port-level checks on the result channel of the triangle solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsts_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata
);

	logic [31:0] sa;
	logic [31:0] sb;
	logic [31:0] sc;
	logic [1:0]  st;
	logic        za;
	logic        zb;
	logic        zc;
	logic        sat;

	assign sa  = m_tdata[47:16];
	assign sb  = m_tdata[79:48];
	assign sc  = m_tdata[111:80];
	assign st  = m_tdata[113:112];
	assign za  = (sa == 32'd0);
	assign zb  = (sb == 32'd0);
	assign zc  = (sc == 32'd0);
	assign sat = (sa == 32'hFFFFFFFF) || (sb == 32'hFFFFFFFF) || (sc == 32'hFFFFFFFF);

	`LSTS_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`LSTS_ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`LSTS_ASSERT_IMPL(a_angle_zero, clk, arst_n, m_tvalid && (st == lsts_pkg::ST_ANGLE), m_tdata[111:0] == 112'd0)
	`LSTS_ASSERT_IMPL(a_zero_sides, clk, arst_n, m_tvalid && (st == lsts_pkg::ST_ZERO), (za && zb) || (za && zc) || (zb && zc))
	`LSTS_ASSERT_IMPL(a_sat_side, clk, arst_n, m_tvalid && (st == lsts_pkg::ST_SAT), sat)

endmodule

bind law_of_sines_triangle_solver lsts_checker u_lsts_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - law_of_sines_triangle_solver testbench
// Drives triangles into the solver over the input stream with random idle
// bursts, predicts each result with a fixed-point CORDIC model of its own and
// compares every output beat in order, field by field.
// ----------------------------------------------------------------------------

module tb;

	localparam int HALF_DEG = 180 << lsts_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int QUARTER_DEG = 90 << lsts_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int N_RANDOM = 1400;

	typedef struct {
		logic [1:0]  op;
		logic [1:0]  ks;
		logic [15:0] a1;
		logic [15:0] a2;
		logic [31:0] len;
		bit          drain_first;
		bit          no_gap;
	} tri_t;

	typedef struct packed {
		logic [15:0] third;
		logic [31:0] sa;
		logic [31:0] sb;
		logic [31:0] sc;
		logic [1:0]  status;
	} sol_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;

	tri_t pending_tris[$];
	sol_t expected_sols[$];
	int   mismatches;
	int   sols_seen;
	int   send_gap;
	int   recv_gap;
	int   hold_cycles;
	bit   hold_done;

	law_of_sines_triangle_solver DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	function automatic longint sine_of(int unsigned ang);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		if (ang > QUARTER_DEG)
			ang = HALF_DEG - ang;
		z = (longint'(ang) * 18740330) >>> lsts_pkg::ANGLE_FRAC_BITS_DEF;
		for (int i = 0; i < lsts_pkg::SINE_STEPS_DEF && i < lsts_pkg::ATAN_ENTRIES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(lsts_pkg::atan_q30(i));
			end else begin
				x += dx; y -= dy; z += longint'(lsts_pkg::atan_q30(i));
			end
		end
		if (y < 0)
			return 0;
		if (y > 1073741824)
			return 1073741824;
		return y;
	endfunction

	function automatic sol_t solve_triangle(tri_t t);
		sol_t r;
		int unsigned ang[3];
		longint unsigned sn[3];
		longint unsigned side[3];
		longint unsigned v;
		int unsigned third;
		r = '0;
		side = '{0, 0, 0};
		third = 0;
		if (t.op == lsts_pkg::OP_NONE || int'(t.a1) + int'(t.a2) >= HALF_DEG) begin
			r.status = lsts_pkg::ST_ANGLE;
		end else begin
			r.status = lsts_pkg::ST_OK;
			third = HALF_DEG - t.a1 - t.a2;
			case (t.op)
				lsts_pkg::OP_ALPHA: ang = '{third, t.a1, t.a2};
				lsts_pkg::OP_BETA:  ang = '{t.a1, third, t.a2};
				default:            ang = '{t.a1, t.a2, third};
			endcase
			if (t.ks == lsts_pkg::SIDE_NONE) begin
				r.status = lsts_pkg::ST_ZERO;
			end else begin
				for (int k = 0; k < 3; k++)
					sn[k] = sine_of(ang[k]);
				side[t.ks] = t.len;
				if (sn[t.ks] == 0) begin
					r.status = lsts_pkg::ST_ZERO;
				end else begin
					for (int k = 0; k < 3; k++) begin
						if (k != t.ks) begin
							v = longint'(t.len) * sn[k] / sn[t.ks];
							if (v > 64'hFFFF_FFFF) begin
								v = 64'hFFFF_FFFF;
								r.status = lsts_pkg::ST_SAT;
							end
							side[k] = v;
						end
					end
				end
			end
		end
		r.third = third[15:0];
		r.sa = side[0][31:0];
		r.sb = side[1][31:0];
		r.sc = side[2][31:0];
		return r;
	endfunction

	function automatic tri_t mk_tri(logic [1:0] op, logic [1:0] ks, logic [15:0] a1,
			logic [15:0] a2, logic [31:0] len);
		tri_t t;
		t = '{op, ks, a1, a2, len, 1'b0, 1'b0};
		return t;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_sols.push_back(solve_triangle(pending_tris[0]));
				pending_tris.pop_front();
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_tris.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pending_tris[0].drain_first && expected_sols.size() != 0) begin
				s_tvalid <= 1'b0;
			end else if (!pending_tris[0].no_gap && !(s_tvalid && !s_tready)
					&& $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(1, 13) - 1;
				s_tvalid <= 1'b0;
			end else begin
				pending_tris[0].drain_first = 1'b0;
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, pending_tris[0].len, pending_tris[0].a2,
					pending_tris[0].a1, pending_tris[0].ks, pending_tris[0].op};
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		sol_t want;
		sol_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.third = m_tdata[15:0];
				got.sa = m_tdata[47:16];
				got.sb = m_tdata[79:48];
				got.sc = m_tdata[111:80];
				got.status = m_tdata[113:112];
				sols_seen++;
				if (expected_sols.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					want = expected_sols.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"beat %0d: exp third %h a %h b %h c %h st %0d, ",
								"got third %h a %h b %h c %h st %0d"},
								sols_seen, want.third, want.sa, want.sb, want.sc,
								want.status, got.third, got.sa, got.sb, got.sc,
								got.status);
					end
				end
			end
			if (!hold_done && sols_seen >= 300) begin
				if (hold_cycles < 400) begin
					hold_cycles <= hold_cycles + 1;
					m_tready <= 1'b0;
				end else begin
					hold_done <= 1'b1;
					m_tready <= 1'b1;
				end
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (sols_seen < 1300 && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(1, 13) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		tri_t t;
		int unsigned a1;
		int kind;
		clk = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		sols_seen = 0;

		for (int op = 0; op < 4; op++)
			pending_tris.push_back(mk_tri(2'(op), 2'(op), 16'd7680, 16'd11520,
				32'h0001_0000));
		for (int ks = 0; ks < 4; ks++)
			pending_tris.push_back(mk_tri(lsts_pkg::OP_GAMMA, 2'(ks), 16'd15360, 16'd15360,
				32'hFFFF_FFFF));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_ALPHA, 2'd0, 16'd0, 16'd0, 32'h0001_0000));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_ALPHA, 2'd1, 16'd0, 16'd23040,
			32'h0001_0000));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_BETA, 2'd0, 16'd46079, 16'd0, 32'hFFFF_FFFF));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_BETA, 2'd1, 16'd46080, 16'd0, 32'h1234_5678));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_GAMMA, 2'd0, 16'd23040, 16'd23040, 32'd1));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_GAMMA, 2'd0, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_GAMMA, 2'd0, 16'd1, 16'd23040,
			32'hFFFF_FFFF));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_ALPHA, 2'd2, 16'd30000, 16'd256,
			32'h8000_0000));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_BETA, 2'd2, 16'd256, 16'd45568, 32'd0));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_GAMMA, 2'd1, 16'd23040, 16'd0,
			32'hFFFF_FFFF));
		pending_tris.push_back(mk_tri(lsts_pkg::OP_NONE, 2'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));

		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			t.op = (kind == 0) ? 2'($urandom) : 2'($urandom_range(0, 2));
			t.ks = (kind == 1) ? 2'($urandom) : 2'($urandom_range(0, 2));
			t.len = $urandom;
			if (kind == 2) begin
				t.a1 = 16'($urandom);
				t.a2 = 16'($urandom);
			end else begin
				a1 = $urandom_range(0, HALF_DEG - 1);
				t.a1 = 16'(a1);
				t.a2 = 16'($urandom_range(0, HALF_DEG - 1 - a1));
				if ($urandom_range(0, 1))
					{t.a1, t.a2} = {t.a2, t.a1};
			end
			if (kind == 3)
				t.len = $urandom_range(0, 255);
			t.drain_first = (n == 700);
			t.no_gap = (n > 1200);
			pending_tris.push_back(t);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_tris.size() == 0 && expected_sols.size() == 0);
		repeat (120) @(posedge clk);
		if (mismatches == 0 && expected_sols.size() == 0)
			$display("law_of_sines_triangle_solver verification clean");
		else
			$display("law_of_sines_triangle_solver verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("law_of_sines_triangle_solver verification failed");
		$finish;
	end

endmodule
